### sv/skconv_pkg.sv
// Shared types and constants of the square-kernel RGB convolver.
// No dependencies; used by skconv_mac and square_kernel_rgb_convolver_unit.
`default_nettype none
package skconv_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int MAX_HALF_DEF       = 25;
    localparam int WINDOW_DEPTH_DEF   = 65536;
    localparam int COEF_FRAC_BITS_DEF = 16;

    localparam int COEF_W = 24;
    localparam int CH_W   = 16;
    localparam int NUM_CH = 3;
    localparam int CFG_W  = 11;

    localparam logic [CH_W-1:0] CH8_MAX  = 16'd255;
    localparam logic [CH_W-1:0] CH16_MAX = 16'd65535;

    typedef enum logic [1:0] {
        OP_COEF  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_HALF    = 2'd2,
        CFG_SIXTEEN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

endpackage
`default_nettype wire

### sv/skconv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module skconv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sv/skconv_mac.sv
// Shared multiply-accumulate unit: one kernel tap for all three colors per cycle.
// Depends on skconv_pkg.
`default_nettype none
module skconv_mac #(
    parameter int ACC_W = 53
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire skconv_pkg::t_mac_ctl          i_ctl,
    input  wire logic signed [skconv_pkg::COEF_W-1:0] i_coef,
    input  wire logic [skconv_pkg::NUM_CH-1:0][skconv_pkg::CH_W-1:0] i_ch,
    output logic signed [skconv_pkg::NUM_CH-1:0][ACC_W-1:0] o_acc
);
    import skconv_pkg::*;

    localparam int PROD_W = COEF_W + CH_W + 1;

    logic                     r_vld;
    logic signed [PROD_W-1:0] r_prod [NUM_CH];

    // product stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld <= 1'b0;
            o_acc <= '0;
        end else begin
            r_vld <= i_ctl.vld;
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_vld) begin
                    o_acc[c] <= o_acc[c] + ACC_W'(r_prod[c]);
                end
            end
        end
        for (int c = 0; c < NUM_CH; c++) begin
            r_prod[c] <= PROD_W'(i_coef * $signed({1'b0, i_ch[c]}));
        end
    end
endmodule
`default_nettype wire

### sv/square_kernel_rgb_convolver_unit.sv
// Top level of the square-kernel RGB convolver: sequencer, window and coefficient RAMs.
// Depends on skconv_pkg, skconv_ram, skconv_mac.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | i_valid/o_ready, i_op, i_coef_*, i_in_*   | in
//  result  | o_valid/i_ready, o_out_*, o_pixel_index,  | out
//          | o_frame_end                               |
//  config  | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// A coefficient load or an unused op passes through S_DECODE only; a request that yields no result also passes S_CHECK.
// A request that yields a result walks all S*S kernel taps in S_TAP, S = 2*half+1, then S_CENTER, S_DRAIN and S_OUT:
// the single MAC unit takes one kernel tap per cycle, fed by one read port of each RAM.
// A finished result waits in the output register; the next request is accepted meanwhile,
// and the sequencer only stalls when a second result is ready before the first is taken.
// Reset (synchronous) clears counters and control; RAM contents are undefined until written.
`default_nettype none
module square_kernel_rgb_convolver_unit #(
    parameter int MAX_WIDTH      = skconv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = skconv_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_HALF       = skconv_pkg::MAX_HALF_DEF,
    parameter int WINDOW_DEPTH   = skconv_pkg::WINDOW_DEPTH_DEF,
    parameter int COEF_FRAC_BITS = skconv_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [11:0] i_coef_index,
    input  wire logic signed [23:0] i_coef_value,
    input  wire logic [15:0] i_in_blue,
    input  wire logic [15:0] i_in_green,
    input  wire logic [15:0] i_in_red,
    input  wire logic [15:0] i_in_alpha,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_out_blue,
    output logic [15:0]      o_out_green,
    output logic [15:0]      o_out_red,
    output logic [15:0]      o_out_alpha,
    output logic [19:0]      o_pixel_index,
    output logic             o_frame_end,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [skconv_pkg::CFG_W-1:0] i_cfg_data
);
    import skconv_pkg::*;

    localparam int COEF_SIDE  = 2 * MAX_HALF + 1;
    localparam int COEF_DEPTH = COEF_SIDE * COEF_SIDE;
    localparam int CAW        = $clog2(COEF_DEPTH);
    localparam int AW         = $clog2(WINDOW_DEPTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HHW        = $clog2(MAX_HEIGHT + 1);
    localparam int HW         = $clog2(MAX_HALF + 1);
    localparam int SW         = HW + 1;
    localparam int SZW        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int QW         = SZW + AW + 2;
    localparam int ACC_W      = COEF_W + CH_W + 1 + $clog2(COEF_DEPTH);
    localparam int PXW        = 4 * CH_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_CHECK, S_TAP, S_CENTER, S_DRAIN, S_OUT
    } t_state;

    // configuration registers
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [4:0]       r_cfg_half;
    logic             r_cfg_16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= CFG_W'(1024);
            r_cfg_h    <= CFG_W'(1024);
            r_cfg_half <= '0;
            r_cfg_16   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:   r_cfg_w    <= i_cfg_data;
                CFG_HEIGHT:  r_cfg_h    <= i_cfg_data;
                CFG_HALF:    r_cfg_half <= i_cfg_data[4:0];
                CFG_SIXTEEN: r_cfg_16   <= i_cfg_data[0];
                default:     r_cfg_16   <= r_cfg_16;
            endcase
        end
    end

    // clamped geometry
    logic [WW-1:0]     w_c;
    logic [HHW-1:0]    h_c;
    logic [HW-1:0]     half_c;
    logic [SW-1:0]     side_m1;
    logic [CH_W-1:0]   ch_max;
    logic [SZW-1:0]    r_size;
    logic [QW-1:0]     r_reach;

    always_comb begin
        if (r_cfg_w == '0) w_c = WW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_c = WW'(MAX_WIDTH);
        else w_c = WW'(r_cfg_w);
        if (r_cfg_h == '0) h_c = HHW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) h_c = HHW'(MAX_HEIGHT);
        else h_c = HHW'(r_cfg_h);
        if (32'(r_cfg_half) > MAX_HALF) half_c = HW'(MAX_HALF);
        else half_c = HW'(r_cfg_half);
        side_m1 = {half_c, 1'b0};
        ch_max  = r_cfg_16 ? CH16_MAX : CH8_MAX;
    end

    always_ff @(posedge i_clk) begin
        r_size  <= SZW'(w_c * h_c);
        r_reach <= QW'(half_c * w_c) + QW'(half_c);
    end

    // sequencer state
    t_state             r_state;
    t_op                r_op;
    logic [11:0]        r_cidx_in;
    logic signed [COEF_W-1:0] r_cval;
    logic [PXW-1:0]     r_px;
    logic [SZW-1:0]     r_pin, r_pout;
    logic signed [QW-1:0] r_row, r_q;
    logic [SW-1:0]      r_kx, r_ky;
    logic [CAW-1:0]     r_cidx;
    logic               r_tap_vld, r_cen_vld;
    logic [1:0]         r_drain;
    logic [CH_W-1:0]    r_alpha;

    // RAM ports
    logic               coef_we, pix_we;
    logic [CAW-1:0]     coef_raddr;
    logic [AW-1:0]      pix_raddr, pix_waddr;
    logic [COEF_W-1:0]  coef_rd;
    logic [PXW-1:0]     pix_rd;
    logic [31:0]        pin32;

    logic signed [QW-1:0] s_size, s_pin, s_pout, q_cur, q_win;
    logic               tap_ok, cen_ok, emit_ok, last_tap, out_free;
    logic signed [NUM_CH-1:0][ACC_W-1:0] acc;
    logic [NUM_CH-1:0][CH_W-1:0] fin, mac_ch;
    t_mac_ctl           mac_ctl;

    always_comb begin
        s_size   = $signed(QW'(r_size));
        s_pin    = $signed(QW'(r_pin));
        s_pout   = $signed(QW'(r_pout));
        q_cur    = r_row + $signed(QW'(r_kx));
        q_win    = q_cur + $signed(QW'(WINDOW_DEPTH));
        tap_ok   = !q_cur[QW-1] && (q_cur < s_size) && (q_cur < s_pin) && (q_win >= s_pin);
        cen_ok   = (s_pout + $signed(QW'(WINDOW_DEPTH))) >= s_pin;
        emit_ok  = (r_pout < r_pin) && (r_op == OP_FLUSH || r_pin >= r_size ||
                   s_pin > s_pout + $signed(r_reach));
        last_tap = (r_kx == side_m1) && (r_ky == side_m1);
        out_free = !o_valid || i_ready;
        pin32    = 32'(r_pin);

        coef_we    = (r_state == S_DECODE) && (r_op == OP_COEF) && (32'(r_cidx_in) < COEF_DEPTH);
        pix_we     = (r_state == S_DECODE) && (r_op == OP_PIXEL) && (r_pin < r_size);
        pix_waddr  = pin32[AW-1:0];
        coef_raddr = r_cidx;
        pix_raddr  = (r_state == S_CENTER) ? r_pout[AW-1:0] : q_cur[AW-1:0];

        mac_ctl.clr = (r_state == S_CHECK);
        mac_ctl.vld = r_tap_vld;
        for (int c = 0; c < NUM_CH; c++) begin
            mac_ch[c] = pix_rd[c*CH_W +: CH_W] & ch_max;
            // floor, then clamp to the channel range
            if ($signed(acc[c]) <= 0) begin
                fin[c] = '0;
            end else if (acc[c][ACC_W-1:COEF_FRAC_BITS] > (ACC_W-COEF_FRAC_BITS)'(ch_max)) begin
                fin[c] = ch_max;
            end else begin
                fin[c] = acc[c][COEF_FRAC_BITS +: CH_W];
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pin     <= '0;
            r_pout    <= '0;
            r_tap_vld <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_tap_vld <= 1'b0;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= t_op'(i_op);
                        r_cidx_in <= i_coef_index;
                        r_cval    <= i_coef_value;
                        r_px      <= {i_in_alpha, i_in_red, i_in_green, i_in_blue};
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (pix_we) begin
                        r_pin <= r_pin + SZW'(1);
                    end
                    if (r_op == OP_PIXEL || r_op == OP_FLUSH) r_state <= S_CHECK;
                    else r_state <= S_IDLE;
                end
                S_CHECK: begin
                    r_row  <= s_pout - $signed(r_reach);
                    r_kx   <= '0;
                    r_ky   <= '0;
                    r_cidx <= '0;
                    r_state <= emit_ok ? S_TAP : S_IDLE;
                end
                S_TAP: begin
                    r_tap_vld <= tap_ok;
                    r_cidx    <= r_cidx + CAW'(1);
                    if (r_kx == side_m1) begin
                        r_kx  <= '0;
                        r_ky  <= r_ky + SW'(1);
                        r_row <= r_row + $signed(QW'(w_c));
                    end else begin
                        r_kx <= r_kx + SW'(1);
                    end
                    if (last_tap) r_state <= S_CENTER;
                end
                S_CENTER: begin
                    r_cen_vld <= cen_ok;
                    r_drain   <= '0;
                    r_state   <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_drain == 2'd0) begin
                        r_alpha <= r_cen_vld ? (pix_rd[3*CH_W +: CH_W] & ch_max) : '0;
                    end
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_out_blue    <= fin[0];
                        o_out_green   <= fin[1];
                        o_out_red     <= fin[2];
                        o_out_alpha   <= r_alpha;
                        o_pixel_index <= 20'(32'(r_pout));
                        if (32'(r_pout) + 32'd1 >= 32'(r_size)) begin
                            o_frame_end <= 1'b1;
                            r_pin       <= '0;
                            r_pout      <= '0;
                        end else begin
                            o_frame_end <= 1'b0;
                            r_pout      <= r_pout + SZW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    skconv_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (r_cidx_in[CAW-1:0]),
        .i_wdata (r_cval),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rd)
    );

    skconv_ram #(.WIDTH(PXW), .DEPTH(WINDOW_DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (r_px),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rd)
    );

    skconv_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  ($signed(coef_rd)),
        .i_ch    (mac_ch),
        .o_acc   (acc)
    );

    a_pout_le_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pout <= r_pin) else $error("output count passed input count");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_valid) else $error("result not loaded");
    a_cidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (32'(r_cidx) < COEF_DEPTH)) else $error("coef index overrun");
    a_tap_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_pout < r_pin)) else $error("tap walk without pending pixel");
endmodule
`default_nettype wire
